FILE: design/hpt_pkg.sv
// ----------------------------------------------------------------------------
// Homogeneous point transform package
// Shared widths, element type and result status codes.
// ----------------------------------------------------------------------------
package hpt_pkg;

  localparam int unsigned ElemW   = 32;
  localparam int unsigned CfgW    = 64;
  localparam int unsigned NumRegs = 8;
  localparam int unsigned CfgIdxW = 4;
  localparam int unsigned NumRows = 4;
  localparam int unsigned NumCols = 4;
  localparam int unsigned NumAxes = 3;

  typedef logic signed [ElemW-1:0] elem_t;

  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_ZERO_W = 2'd1,
    STATUS_SAT    = 2'd2
  } status_e;

endpackage

FILE: design/homogeneous_point_transform_top.sv
// ----------------------------------------------------------------------------
// Homogeneous point transform with perspective divide
// One transaction per cycle unless the consumer stalls a full output register;
// the pipeline depth is set by the bit-per-stage reciprocal divider.
// Reset loads the identity matrix and empties the pipeline.
// ----------------------------------------------------------------------------
module homogeneous_point_transform_top #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [hpt_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [hpt_pkg::CfgW-1:0]        cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  hpt_pkg::elem_t                  point_x_i,
  input  hpt_pkg::elem_t                  point_y_i,
  input  hpt_pkg::elem_t                  point_z_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output hpt_pkg::elem_t                  mapped_x_o,
  output hpt_pkg::elem_t                  mapped_y_o,
  output hpt_pkg::elem_t                  mapped_z_o,
  output hpt_pkg::elem_t                  inverse_weight_o,
  output logic [1:0]                      status_o
);
  import hpt_pkg::*;

  // Width of a dot product: 66-bit product sum, floored, plus the offset.
  localparam int unsigned VW   = 2 * ElemW + 2 - FRAC_BITS + 1;
  // Quotient / divisor width of the reciprocal.
  localparam int unsigned QW   = 2 * FRAC_BITS + 2;
  localparam int unsigned FW   = QW - 1;
  // A coordinate magnitude at or above 2^(FRAC_BITS+33) saturates unless the
  // reciprocal is zero, so only that many bits go to the multipliers.
  localparam int unsigned AW   = (VW < FRAC_BITS + 33) ? VW : FRAC_BITS + 33;
  localparam int unsigned CmpW = (VW > QW) ? VW : QW;
  localparam int unsigned InvW = (FW > ElemW + 1) ? FW : ElemW + 1;
  localparam int unsigned LaneW = AW + 2;
  localparam int unsigned SideW = NumAxes * LaneW + 3;
  // Stages ahead of the output register: two dot, magnitude, divider,
  // reciprocal rounding and three scaling stages.
  localparam int unsigned NV   = QW + 7;
  localparam int unsigned SclD = 3;

  localparam logic [CfgW-1:0] OneLo = CfgW'(1) << FRAC_BITS;
  localparam logic [CfgW-1:0] OneHi = OneLo << ElemW;

  // --------------------------------------------------------------------------
  // Configuration registers: two matrix elements per register.
  // --------------------------------------------------------------------------
  logic [CfgW-1:0] cfg_q [NumRegs];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q[0] <= OneLo;
      cfg_q[1] <= '0;
      cfg_q[2] <= OneHi;
      cfg_q[3] <= '0;
      cfg_q[4] <= '0;
      cfg_q[5] <= OneLo;
      cfg_q[6] <= '0;
      cfg_q[7] <= OneHi;
    end else if (cfg_we_i && (cfg_index_i < CfgIdxW'(NumRegs))) begin
      cfg_q[cfg_index_i[$clog2(NumRegs)-1:0]] <= cfg_data_i;
    end
  end

  elem_t coef [NumRows][NumCols];

  always_comb begin
    for (int r = 0; r < NumRows; r++) begin
      for (int c = 0; c < NumCols; c++) begin
        coef[r][c] = (c % 2 == 1) ? cfg_q[2*r + c/2][CfgW-1:ElemW]
                                  : cfg_q[2*r + c/2][ElemW-1:0];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Flow control. The whole pipeline moves as one; it holds only when the
  // output register is full and the consumer stalls, so a new transaction
  // is taken every cycle otherwise.
  // --------------------------------------------------------------------------
  logic            adv;
  logic [NV-1:0]   vld_q;
  logic            out_valid_q;

  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      vld_q       <= {vld_q[NV-2:0], in_valid_i};
      out_valid_q <= vld_q[NV-1];
    end
  end

  // --------------------------------------------------------------------------
  // Four dot product lanes, one per matrix row.
  // --------------------------------------------------------------------------
  elem_t                pt [NumAxes];
  logic signed [VW-1:0] v  [NumRows];

  assign pt[0] = point_x_i;
  assign pt[1] = point_y_i;
  assign pt[2] = point_z_i;

  for (genvar r = 0; r < NumRows; r++) begin : g_dot
    hpt_dot #(
      .FRAC_BITS (FRAC_BITS),
      .VW        (VW)
    ) u_dot (
      .clk_i  (clk_i),
      .adv_i  (adv),
      .coef_i (coef[r]),
      .pt_i   (pt),
      .v_o    (v[r])
    );
  end

  // --------------------------------------------------------------------------
  // Magnitude stage: split every result into sign and magnitude, flag a zero
  // weight and a weight too large for a nonzero reciprocal.
  // --------------------------------------------------------------------------
  logic [VW-1:0]    vmag [NumRows];
  logic [SideW-1:0] side_d, side_q;
  logic [QW-1:0]    dvs_d, dvs_q;

  always_comb begin
    for (int r = 0; r < NumRows; r++) begin
      vmag[r] = v[r][VW-1] ? VW'(-v[r]) : VW'(v[r]);
    end
    for (int r = 0; r < NumAxes; r++) begin
      side_d[r*LaneW +: LaneW] = {v[r][VW-1], (|(vmag[r] >> AW)), AW'(vmag[r])};
    end
    side_d[SideW-1] = CmpW'(vmag[NumRows-1]) > (CmpW'(1) << (2 * FRAC_BITS + 1));
    side_d[SideW-2] = (v[NumRows-1] == '0);
    side_d[SideW-3] = v[NumRows-1][VW-1];
    dvs_d           = QW'(vmag[NumRows-1]);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_q <= side_d;
      dvs_q  <= dvs_d;
    end
  end

  // --------------------------------------------------------------------------
  // Reciprocal: floor(2^(2F+1)/|w|), then halved with rounding.
  // --------------------------------------------------------------------------
  logic [QW-1:0]    quo;
  logic [SideW-1:0] side_dv;

  hpt_recip #(
    .FRAC_BITS (FRAC_BITS),
    .SIDE_W    (SideW)
  ) u_recip (
    .clk_i  (clk_i),
    .adv_i  (adv),
    .div_i  (dvs_q),
    .side_i (side_q),
    .quo_o  (quo),
    .side_o (side_dv)
  );

  logic [FW-1:0]    fmag_q;
  logic [AW-1:0]    mag_q   [NumAxes];
  logic             huge_q  [NumAxes];
  logic             neg_q   [NumAxes];
  logic             wneg_q;
  logic             zero_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      fmag_q <= side_dv[SideW-1] ? '0 : FW'((quo + QW'(1)) >> 1);
      for (int r = 0; r < NumAxes; r++) begin
        mag_q[r]  <= side_dv[r*LaneW +: AW];
        huge_q[r] <= side_dv[r*LaneW + AW];
        neg_q[r]  <= side_dv[r*LaneW + AW + 1] ^ side_dv[SideW-3];
      end
      wneg_q <= side_dv[SideW-3];
      zero_q <= side_dv[SideW-2];
    end
  end

  // --------------------------------------------------------------------------
  // Three scaling lanes, one per axis.
  // --------------------------------------------------------------------------
  elem_t lane_val [NumAxes];
  logic  lane_sat [NumAxes];

  for (genvar r = 0; r < NumAxes; r++) begin : g_scale
    hpt_scale #(
      .FRAC_BITS (FRAC_BITS),
      .AW        (AW),
      .FW        (FW)
    ) u_scale (
      .clk_i  (clk_i),
      .adv_i  (adv),
      .mag_i  (mag_q[r]),
      .huge_i (huge_q[r]),
      .neg_i  (neg_q[r]),
      .fmag_i (fmag_q),
      .val_o  (lane_val[r]),
      .sat_o  (lane_sat[r])
    );
  end

  // The reciprocal output is saturated here and delayed to line up with the
  // scaling lanes.
  logic [InvW-1:0] fext;
  elem_t           inv_d;
  logic            isat_d;
  elem_t           inv_q  [SclD];
  logic            isat_q [SclD];
  logic            zdl_q  [SclD];

  assign fext = InvW'(fmag_q);

  always_comb begin
    if (wneg_q) begin
      isat_d = fext > (InvW'(1) << (ElemW - 1));
      inv_d  = isat_d ? {1'b1, {(ElemW-1){1'b0}}} : -ElemW'(fext);
    end else begin
      isat_d = fext > ((InvW'(1) << (ElemW - 1)) - InvW'(1));
      inv_d  = isat_d ? {1'b0, {(ElemW-1){1'b1}}} : ElemW'(fext);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      inv_q[0]  <= inv_d;
      isat_q[0] <= isat_d;
      zdl_q[0]  <= zero_q;
      for (int s = 1; s < SclD; s++) begin
        inv_q[s]  <= inv_q[s-1];
        isat_q[s] <= isat_q[s-1];
        zdl_q[s]  <= zdl_q[s-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Merge and output register. A zero weight forces zeros; any saturated
  // field otherwise raises the saturation status.
  // --------------------------------------------------------------------------
  elem_t   mx_q, my_q, mz_q, mi_q;
  status_e st_d, st_q;

  always_comb begin
    if (zdl_q[SclD-1]) begin
      st_d = STATUS_ZERO_W;
    end else if (lane_sat[0] || lane_sat[1] || lane_sat[2] || isat_q[SclD-1]) begin
      st_d = STATUS_SAT;
    end else begin
      st_d = STATUS_OK;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mx_q <= zdl_q[SclD-1] ? '0 : lane_val[0];
      my_q <= zdl_q[SclD-1] ? '0 : lane_val[1];
      mz_q <= zdl_q[SclD-1] ? '0 : lane_val[2];
      mi_q <= zdl_q[SclD-1] ? '0 : inv_q[SclD-1];
      st_q <= st_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign mapped_x_o       = mx_q;
  assign mapped_y_o       = my_q;
  assign mapped_z_o       = mz_q;
  assign inverse_weight_o = mi_q;
  assign status_o         = st_q;

endmodule

FILE: design/hpt_dot.sv
// ----------------------------------------------------------------------------
// Dot product lane
// One matrix row times the point: three products, then the floored sum
// plus the row's offset column. Two register stages.
// ----------------------------------------------------------------------------
module hpt_dot #(
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned VW        = 51
) (
  input  logic                  clk_i,
  input  logic                  adv_i,
  input  hpt_pkg::elem_t        coef_i [hpt_pkg::NumCols],
  input  hpt_pkg::elem_t        pt_i   [hpt_pkg::NumAxes],
  output logic signed [VW-1:0]  v_o
);
  import hpt_pkg::*;

  localparam int unsigned ProdW = 2 * ElemW;
  localparam int unsigned SumW  = ProdW + 2;

  logic signed [ProdW-1:0] prod_d [NumAxes];
  logic signed [ProdW-1:0] prod_q [NumAxes];
  elem_t                   off_q;
  logic signed [SumW-1:0]  sum;
  logic signed [VW-1:0]    v_d;
  logic signed [VW-1:0]    v_q;

  always_comb begin
    for (int c = 0; c < NumAxes; c++) begin
      prod_d[c] = coef_i[c] * pt_i[c];
    end
  end

  // The exact sum floored once equals the per-term floors plus the carry of
  // the fractional parts.
  assign sum = SumW'(prod_q[0]) + SumW'(prod_q[1]) + SumW'(prod_q[2]);
  assign v_d = VW'(sum >>> FRAC_BITS) + VW'(off_q);

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      prod_q <= prod_d;
      off_q  <= coef_i[NumCols-1];
      v_q    <= v_d;
    end
  end

  assign v_o = v_q;

endmodule

FILE: design/hpt_recip.sv
// ----------------------------------------------------------------------------
// Reciprocal divider
// Pipelined restoring division of 2^(2F+1) by the weight magnitude, one
// quotient bit per stage, with side data carried alongside.
// ----------------------------------------------------------------------------
module hpt_recip #(
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned SIDE_W    = 128
) (
  input  logic                      clk_i,
  input  logic                      adv_i,
  input  logic [2*FRAC_BITS+1:0]    div_i,
  input  logic [SIDE_W-1:0]         side_i,
  output logic [2*FRAC_BITS+1:0]    quo_o,
  output logic [SIDE_W-1:0]         side_o
);

  localparam int unsigned QW = 2 * FRAC_BITS + 2;
  localparam int unsigned RW = QW + 1;

  logic [RW-1:0]     rem_d  [QW];
  logic [RW-1:0]     rem_q  [QW];
  logic [QW-1:0]     quo_d  [QW];
  logic [QW-1:0]     quo_q  [QW];
  logic [QW-1:0]     div_d  [QW];
  logic [QW-1:0]     div_q  [QW];
  logic [SIDE_W-1:0] side_d [QW];
  logic [SIDE_W-1:0] side_q [QW];

  always_comb begin
    logic [RW-1:0]     r_in;
    logic [QW-1:0]     q_in;
    logic [QW-1:0]     d_in;
    logic [SIDE_W-1:0] s_in;
    logic [RW-1:0]     trial;
    logic              nbit;
    logic              ge;
    for (int k = 0; k < QW; k++) begin
      if (k == 0) begin
        r_in = '0;
        q_in = '0;
        d_in = div_i;
        s_in = side_i;
      end else begin
        r_in = rem_q[k-1];
        q_in = quo_q[k-1];
        d_in = div_q[k-1];
        s_in = side_q[k-1];
      end
      // The dividend has a single set bit, which enters at the first stage.
      nbit      = (k == 0);
      trial     = {r_in[RW-2:0], nbit};
      ge        = (trial >= {1'b0, d_in});
      rem_d[k]  = ge ? (trial - {1'b0, d_in}) : trial;
      quo_d[k]  = {q_in[QW-2:0], ge};
      div_d[k]  = d_in;
      side_d[k] = s_in;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      rem_q  <= rem_d;
      quo_q  <= quo_d;
      div_q  <= div_d;
      side_q <= side_d;
    end
  end

  assign quo_o  = quo_q[QW-1];
  assign side_o = side_q[QW-1];

endmodule

FILE: design/hpt_scale.sv
// ----------------------------------------------------------------------------
// Scaling lane
// Multiplies one coordinate magnitude by the reciprocal, rounds half away
// from zero, applies the sign and saturates. Three register stages.
// ----------------------------------------------------------------------------
module hpt_scale #(
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned AW        = 49,
  parameter int unsigned FW        = 33
) (
  input  logic            clk_i,
  input  logic            adv_i,
  input  logic [AW-1:0]   mag_i,
  input  logic            huge_i,
  input  logic            neg_i,
  input  logic [FW-1:0]   fmag_i,
  output hpt_pkg::elem_t  val_o,
  output logic            sat_o
);
  import hpt_pkg::*;

  localparam int unsigned LoW  = ElemW + FW;
  localparam int unsigned HiW  = AW - ElemW + FW;
  localparam int unsigned PW   = AW + FW;
  localparam int unsigned RndW = PW - FRAC_BITS;

  logic [LoW-1:0]  plo_q;
  logic [HiW-1:0]  phi_q;
  logic [PW-1:0]   prod_d;
  logic [PW-1:0]   prod_q;
  logic [RndW-1:0] rnd;
  logic [RndW-1:0] lim;
  logic            force_a_q, force_b_q;
  logic            neg_a_q, neg_b_q;
  logic            sat_d;
  elem_t           val_d;
  elem_t           val_q;
  logic            sat_q;

  assign prod_d = (PW'(phi_q) << ElemW) + PW'(plo_q) + (PW'(1) << (FRAC_BITS - 1));

  assign rnd   = RndW'(prod_q >> FRAC_BITS);
  assign lim   = neg_b_q ? (RndW'(1) << (ElemW - 1)) : ((RndW'(1) << (ElemW - 1)) - RndW'(1));
  assign sat_d = force_b_q || (rnd > lim);

  always_comb begin
    if (sat_d) begin
      val_d = neg_b_q ? {1'b1, {(ElemW-1){1'b0}}} : {1'b0, {(ElemW-1){1'b1}}};
    end else if (neg_b_q) begin
      val_d = -ElemW'(rnd);
    end else begin
      val_d = ElemW'(rnd);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      plo_q     <= LoW'(mag_i[ElemW-1:0]) * LoW'(fmag_i);
      phi_q     <= HiW'(mag_i[AW-1:ElemW]) * HiW'(fmag_i);
      // A magnitude beyond the clamped width saturates unless the factor is zero.
      force_a_q <= huge_i && (fmag_i != '0);
      neg_a_q   <= neg_i;
      prod_q    <= prod_d;
      force_b_q <= force_a_q;
      neg_b_q   <= neg_a_q;
      val_q     <= val_d;
      sat_q     <= sat_d;
    end
  end

  assign val_o = val_q;
  assign sat_o = sat_q;

endmodule
